[hw/rtl/lob_pkg.sv]
package lob_pkg;

  localparam int DEF_MAX_ORDERS = 256;
  localparam int DEF_MAX_LEVELS = 32;
  localparam int DEPTH_CAP      = 32;
  localparam int DEPTH_W        = 7;   // holds up to 127 levels
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_DEPTH  = 2'd3
  } lob_mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } lob_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_ADD,
    S_DROP,
    S_SET,
    S_LOAD,
    S_DEPTH,
    S_RESP
  } lob_state_t;

  typedef struct packed {
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } lob_slot_t;

  // level chain commands
  typedef struct packed {
    logic ins;
    logic inc;
    logic dec;
    logic del;
    logic set_tot;
  } lob_lvl_op_t;

  // level chain status
  typedef struct packed {
    logic hit;
    logic hit_last;
    logic full;
    logic head_vld;
  } lob_lvl_st_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? U32_MAX : s[31:0];
  endfunction

endpackage

[hw/rtl/lob_ifs.sv]
interface lob_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] order_id;
  logic        side;
  logic [31:0] price;
  logic [31:0] quantity;
  logic [5:0]  num_levels;

  modport source (output valid, mode, order_id, side, price, quantity, num_levels,
                  input ready);
  modport sink   (input valid, mode, order_id, side, price, quantity, num_levels,
                  output ready);
endinterface

interface lob_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        best_bid;
  logic [31:0]        best_ask;
  logic signed [32:0] spread;
  logic [31:0]        mid_price;
  logic [8:0]         order_count;
  logic               book_empty;
  logic               level_valid;
  logic [31:0]        level_price;
  logic [31:0]        level_quantity;
  logic               last;

  modport source (output valid, status, best_bid, best_ask, spread, mid_price, order_count,
                  book_empty, level_valid, level_price, level_quantity, last,
                  input ready);
  modport sink   (input valid, status, best_bid, best_ask, spread, mid_price, order_count,
                  book_empty, level_valid, level_price, level_quantity, last,
                  output ready);
endinterface

[hw/rtl/limit_order_book.sv]
// Sequence: add, cancel and remove sweep the order table, decide, update and give their one
//   result (rejected or not-found items skip the update); a remove or cancel that leaves its
//   level populated adds a second sweep to re-total the level before the result.
// Items: one item at a time; the sweep over the order table reads one slot per cycle
//   through its single read port. Depth results follow one level at a time, each after the last is taken.
// Reset: synchronous, active low; slot valid bits, level cells and counters clear.
module limit_order_book import lob_pkg::*; #(
  parameter int MAX_ORDERS = DEF_MAX_ORDERS,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic      clk,
  input  logic      rst_n,
  lob_in_if.sink    in_if,
  lob_out_if.source out_if
);

  localparam int SLOT_W = $clog2(MAX_ORDERS);
  localparam int CNT_W  = $clog2(MAX_ORDERS+1);
  localparam int LIDX_W = $clog2(MAX_LEVELS);
  localparam int LCNT_W = $clog2(MAX_LEVELS+1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  lob_state_t  state_r, state_nxt;
  lob_mode_t   mode_r;
  logic [31:0] id_r, price_r, qty_r;
  logic        side_r;
  lob_status_t status_r;

  // order table: valid bits in flops, payload in a memory
  logic      valid_r [MAX_ORDERS];
  lob_slot_t mem_r   [MAX_ORDERS];
  logic [CNT_W-1:0] resting_r;

  // sweep pipeline: address stage then evaluate stage
  logic [SLOT_W-1:0] scan_k_r;
  logic              rd_live_r;
  logic [SLOT_W-1:0] rd_k_r;
  logic              rd_vld_r;
  lob_slot_t         rd_ent_r;
  logic              sum_phase_r;   // second sweep re-totals a level

  // best candidate found so far in the sweep
  logic              cand_found_r, cand_found_nxt;
  logic [SLOT_W-1:0] cand_k_r, cand_k_nxt;
  logic              cand_side_r, cand_side_nxt;
  logic [31:0]       cand_price_r, cand_price_nxt;
  logic [31:0]       sum_r, sum_nxt;

  // depth query
  logic [DEPTH_W-1:0] dep_n_r, dep_i_r;

  // output register
  logic               out_valid_r;
  lob_status_t        out_status_r;
  logic [31:0]        out_bb_r, out_ba_r, out_mid_r;
  logic signed [32:0] out_spread_r;
  logic [8:0]         out_cnt_r;
  logic               out_empty_r, out_lvl_vld_r, out_last_r;
  logic [31:0]        out_lvl_price_r, out_lvl_qty_r;

  // ---------------------------------------------------------------------------
  // Level chains, one per side
  // ---------------------------------------------------------------------------
  lob_lvl_op_t      op, op_bid, op_ask;
  lob_lvl_st_t      st_bid, st_ask, st_sel;
  logic [31:0]      bid_head, ask_head, bid_rd_price, bid_rd_total, ask_rd_price, ask_rd_total;
  logic [LCNT_W-1:0] bid_used, ask_used;
  logic [LIDX_W-1:0] rd_idx;

  assign rd_idx = dep_i_r[LIDX_W-1:0];
  assign op_bid = side_r ? '0 : op;
  assign op_ask = side_r ? op : '0;
  assign st_sel = side_r ? st_ask : st_bid;

  lob_level_chain #(.MAX_LEVELS(MAX_LEVELS), .CNT_W(CNT_W), .IS_ASK(1'b0)) u_bid (
    .clk(clk), .rst_n(rst_n), .op(op_bid), .key(price_r), .qty(qty_r), .tot_in(sum_r),
    .rd_idx(rd_idx), .rd_price(bid_rd_price), .rd_total(bid_rd_total),
    .head_price(bid_head), .used(bid_used), .st(st_bid)
  );

  lob_level_chain #(.MAX_LEVELS(MAX_LEVELS), .CNT_W(CNT_W), .IS_ASK(1'b1)) u_ask (
    .clk(clk), .rst_n(rst_n), .op(op_ask), .key(price_r), .qty(qty_r), .tot_in(sum_r),
    .rd_idx(rd_idx), .rd_price(ask_rd_price), .rd_total(ask_rd_total),
    .head_price(ask_head), .used(ask_used), .st(st_ask)
  );

  // ---------------------------------------------------------------------------
  // Sweep evaluation
  //   add    : first free slot
  //   cancel : id match at the best level, bids before asks, lowest slot on a tie
  //   remove : lowest slot matching id, side and price
  //   re-total: saturating sum of quantities at side and price
  // ---------------------------------------------------------------------------
  logic id_hit, lvl_hit, better;

  assign id_hit  = rd_vld_r && (rd_ent_r.order_id == id_r);
  assign lvl_hit = rd_vld_r && (rd_ent_r.side == side_r) && (rd_ent_r.price == price_r);
  assign better  = !cand_found_r || (!rd_ent_r.side && cand_side_r) ||
                   ((rd_ent_r.side == cand_side_r) &&
                    (rd_ent_r.side ? (rd_ent_r.price < cand_price_r)
                                   : (rd_ent_r.price > cand_price_r)));

  always_comb begin
    cand_found_nxt = cand_found_r;
    cand_k_nxt     = cand_k_r;
    cand_side_nxt  = cand_side_r;
    cand_price_nxt = cand_price_r;
    sum_nxt        = sum_r;
    if (state_r == S_DROP) begin
      // fresh total for the re-total sweep
      sum_nxt = '0;
    end else if (rd_live_r) begin
      if (sum_phase_r) begin
        if (lvl_hit) sum_nxt = sat_add32(sum_r, rd_ent_r.quantity);
      end else begin
        case (mode_r)
          MODE_ADD: begin
            if (!rd_vld_r && !cand_found_r) begin
              cand_found_nxt = 1'b1;
              cand_k_nxt     = rd_k_r;
            end
          end
          MODE_CANCEL: begin
            if (id_hit && better) begin
              cand_found_nxt = 1'b1;
              cand_k_nxt     = rd_k_r;
              cand_side_nxt  = rd_ent_r.side;
              cand_price_nxt = rd_ent_r.price;
            end
          end
          MODE_REMOVE: begin
            if (id_hit && lvl_hit && !cand_found_r) begin
              cand_found_nxt = 1'b1;
              cand_k_nxt     = rd_k_r;
              cand_side_nxt  = rd_ent_r.side;
              cand_price_nxt = rd_ent_r.price;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  logic in_txn, out_txn, scan_last;

  assign in_txn    = in_if.valid && in_if.ready;
  assign out_txn   = out_if.valid && out_if.ready;
  assign scan_last = (scan_k_r == SLOT_W'(MAX_ORDERS-1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_txn) begin
          if (lob_mode_t'(in_if.mode) == MODE_DEPTH) state_nxt = S_DEPTH;
          else                                       state_nxt = S_SCAN;
        end
      end
      S_SCAN:     if (scan_last) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sum_phase_r) begin
          state_nxt = S_SET;
        end else if (mode_r == MODE_ADD) begin
          if (!cand_found_r || (!st_sel.hit && st_sel.full)) state_nxt = S_LOAD;
          else                                               state_nxt = S_ADD;
        end else begin
          state_nxt = cand_found_r ? S_DROP : S_LOAD;
        end
      end
      S_ADD:   state_nxt = S_LOAD;
      S_DROP:  state_nxt = st_sel.hit_last ? S_LOAD : S_SCAN;
      S_SET:   state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_RESP;
      S_DEPTH: state_nxt = S_RESP;
      S_RESP: begin
        if (out_txn) begin
          if (mode_r == MODE_DEPTH && !out_last_r) state_nxt = S_DEPTH;
          else                                     state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Decoded controls
  // ---------------------------------------------------------------------------
  always_comb begin
    op          = '0;
    in_if.ready = 1'b0;
    unique case (state_r)
      S_IDLE: in_if.ready = 1'b1;
      S_ADD: begin
        op.inc = st_sel.hit;
        op.ins = !st_sel.hit;
      end
      S_DROP: begin
        op.del = st_sel.hit_last;
        op.dec = !st_sel.hit_last;
      end
      S_SET:  op.set_tot = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Top-of-book view for every result
  // ---------------------------------------------------------------------------
  logic [31:0] bb, ba;
  logic        both;
  logic [32:0] pair_sum;
  logic [DEPTH_W-1:0] req_n, used_n;

  assign bb       = st_bid.head_vld ? bid_head : 32'd0;
  assign ba       = st_ask.head_vld ? ask_head : 32'd0;
  assign both     = (bb != 32'd0) && (ba != 32'd0);
  assign pair_sum = {1'b0, bb} + {1'b0, ba};

  // levels a depth query will report: min(used, requested, cap)
  always_comb begin
    used_n = in_if.side ? DEPTH_W'(ask_used) : DEPTH_W'(bid_used);
    req_n  = DEPTH_W'(in_if.num_levels);
    if (used_n < req_n) req_n = used_n;
    if (req_n > DEPTH_W'(DEPTH_CAP)) req_n = DEPTH_W'(DEPTH_CAP);
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      resting_r    <= '0;
      out_valid_r  <= 1'b0;
      rd_live_r    <= 1'b0;
      sum_phase_r  <= 1'b0;
      cand_found_r <= 1'b0;
      for (int i = 0; i < MAX_ORDERS; i++) valid_r[i] <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_live_r <= (state_r == S_SCAN);
      if (state_r == S_IDLE && in_txn) begin
        sum_phase_r  <= 1'b0;
        cand_found_r <= 1'b0;
      end else begin
        cand_found_r <= cand_found_nxt;
      end
      if (state_r == S_ADD) begin
        valid_r[cand_k_r] <= 1'b1;
        resting_r         <= resting_r + CNT_W'(1);
      end
      if (state_r == S_DROP) begin
        valid_r[cand_k_r] <= 1'b0;
        resting_r         <= resting_r - CNT_W'(1);
        sum_phase_r       <= 1'b1;
      end
      if (state_r == S_LOAD || state_r == S_DEPTH) out_valid_r <= 1'b1;
      else if (out_txn)                            out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    cand_k_r     <= cand_k_nxt;
    cand_side_r  <= cand_side_nxt;
    cand_price_r <= cand_price_nxt;
    sum_r        <= sum_nxt;

    // single read port of the order table
    rd_k_r   <= scan_k_r;
    rd_vld_r <= valid_r[scan_k_r];
    rd_ent_r <= mem_r[scan_k_r];

    if (state_r == S_SCAN) scan_k_r <= scan_k_r + SLOT_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_txn) begin
          mode_r   <= lob_mode_t'(in_if.mode);
          id_r     <= in_if.order_id;
          side_r   <= in_if.side;
          price_r  <= in_if.price;
          qty_r    <= in_if.quantity;
          status_r <= STAT_OK;
          scan_k_r <= '0;
          dep_n_r  <= req_n;
          dep_i_r  <= '0;
        end
      end
      S_DECIDE: begin
        if (!sum_phase_r) begin
          if (mode_r == MODE_ADD) begin
            if (!cand_found_r || (!st_sel.hit && st_sel.full)) status_r <= STAT_FULL;
          end else if (cand_found_r) begin
            // level of the order found drives the drop
            side_r  <= cand_side_r;
            price_r <= cand_price_r;
          end else begin
            status_r <= STAT_NOT_FOUND;
          end
        end
      end
      S_ADD: begin
        mem_r[cand_k_r] <= '{order_id: id_r, side: side_r, price: price_r, quantity: qty_r};
      end
      S_DROP: begin
        scan_k_r <= '0;
      end
      S_RESP: begin
        if (out_txn) dep_i_r <= dep_i_r + DEPTH_W'(1);
      end
      default: ;
    endcase

    // result register: book view after the item's update
    if (state_r == S_LOAD || state_r == S_DEPTH) begin
      out_status_r <= (state_r == S_LOAD) ? status_r : STAT_OK;
      out_bb_r     <= bb;
      out_ba_r     <= ba;
      out_spread_r <= both ? ($signed({1'b0, ba}) - $signed({1'b0, bb})) : 33'sd0;
      out_mid_r    <= both ? pair_sum[32:1] : 32'd0;
      out_cnt_r    <= 9'(resting_r);
      out_empty_r  <= !st_bid.head_vld && !st_ask.head_vld;
      if (state_r == S_DEPTH && dep_n_r != '0) begin
        out_lvl_vld_r   <= 1'b1;
        out_lvl_price_r <= side_r ? ask_rd_price : bid_rd_price;
        out_lvl_qty_r   <= side_r ? ask_rd_total : bid_rd_total;
        out_last_r      <= (dep_i_r + DEPTH_W'(1) == dep_n_r);
      end else begin
        // status-only result, also an empty depth answer
        out_lvl_vld_r   <= 1'b0;
        out_lvl_price_r <= 32'd0;
        out_lvl_qty_r   <= 32'd0;
        out_last_r      <= 1'b1;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.best_bid       = out_bb_r;
  assign out_if.best_ask       = out_ba_r;
  assign out_if.spread         = out_spread_r;
  assign out_if.mid_price      = out_mid_r;
  assign out_if.order_count    = out_cnt_r;
  assign out_if.book_empty     = out_empty_r;
  assign out_if.level_valid    = out_lvl_vld_r;
  assign out_if.level_price    = out_lvl_price_r;
  assign out_if.level_quantity = out_lvl_qty_r;
  assign out_if.last           = out_last_r;

endmodule

[hw/rtl/lob_level_cell.sv]
module lob_level_cell import lob_pkg::*; #(
  parameter int CNT_W  = 9,
  parameter bit IS_ASK = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lob_lvl_op_t       op,
  input  logic [31:0]       key,
  input  logic [31:0]       qty,
  input  logic [31:0]       tot_in,
  input  logic [31:0]       left_price,
  input  logic [31:0]       left_total,
  input  logic [CNT_W-1:0]  left_orders,
  input  logic              left_valid,
  input  logic              left_beyond,
  input  logic [31:0]       right_price,
  input  logic [31:0]       right_total,
  input  logic [CNT_W-1:0]  right_orders,
  input  logic              right_valid,
  output logic [31:0]       price_o,
  output logic [31:0]       total_o,
  output logic [CNT_W-1:0]  orders_o,
  output logic              valid_o,
  output logic              beyond_o,
  output logic              match_o
);

  logic [31:0]      price_r, price_nxt;
  logic [31:0]      total_r, total_nxt;
  logic [CNT_W-1:0] orders_r, orders_nxt;
  logic             valid_r, valid_nxt;
  logic             match, beyond;

  assign match  = valid_r && (price_r == key);
  // an empty cell, or one whose price ranks worse than the key
  assign beyond = !valid_r || (IS_ASK ? (price_r > key) : (price_r < key));

  always_comb begin
    price_nxt  = price_r;
    total_nxt  = total_r;
    orders_nxt = orders_r;
    valid_nxt  = valid_r;
    if (op.ins) begin
      if (left_beyond) begin
        price_nxt  = left_price;
        total_nxt  = left_total;
        orders_nxt = left_orders;
        valid_nxt  = left_valid;
      end else if (beyond) begin
        price_nxt  = key;
        total_nxt  = qty;
        orders_nxt = CNT_W'(1);
        valid_nxt  = 1'b1;
      end
    end
    if (op.inc && match) begin
      orders_nxt = orders_r + CNT_W'(1);
      total_nxt  = sat_add32(total_r, qty);
    end
    if (op.dec && match) begin
      orders_nxt = orders_r - CNT_W'(1);
    end
    if (op.set_tot && match) begin
      total_nxt = tot_in;
    end
    if (op.del && (match || beyond)) begin
      price_nxt  = right_price;
      total_nxt  = right_total;
      orders_nxt = right_orders;
      valid_nxt  = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    price_r  <= price_nxt;
    total_r  <= total_nxt;
    orders_r <= orders_nxt;
  end

  assign price_o  = price_r;
  assign total_o  = total_r;
  assign orders_o = orders_r;
  assign valid_o  = valid_r;
  assign beyond_o = beyond;
  assign match_o  = match;

endmodule

[hw/rtl/lob_level_chain.sv]
module lob_level_chain import lob_pkg::*; #(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int CNT_W      = 9,
  parameter bit IS_ASK     = 1'b0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lob_lvl_op_t                       op,
  input  logic [31:0]                       key,
  input  logic [31:0]                       qty,
  input  logic [31:0]                       tot_in,
  input  logic [$clog2(MAX_LEVELS)-1:0]     rd_idx,
  output logic [31:0]                       rd_price,
  output logic [31:0]                       rd_total,
  output logic [31:0]                       head_price,
  output logic [$clog2(MAX_LEVELS+1)-1:0]   used,
  output lob_lvl_st_t                       st
);

  localparam int LCNT_W = $clog2(MAX_LEVELS+1);

  logic [31:0]      c_price  [MAX_LEVELS];
  logic [31:0]      c_total  [MAX_LEVELS];
  logic [CNT_W-1:0] c_orders [MAX_LEVELS];
  logic             c_valid  [MAX_LEVELS];
  logic             c_beyond [MAX_LEVELS];
  logic             c_match  [MAX_LEVELS];
  logic [LCNT_W-1:0] used_r;

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    lob_level_cell #(.CNT_W(CNT_W), .IS_ASK(IS_ASK)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op           (op),
      .key          (key),
      .qty          (qty),
      .tot_in       (tot_in),
      .left_price   ((i == 0) ? 32'd0        : c_price[(i == 0) ? 0 : i-1]),
      .left_total   ((i == 0) ? 32'd0        : c_total[(i == 0) ? 0 : i-1]),
      .left_orders  ((i == 0) ? CNT_W'(0)    : c_orders[(i == 0) ? 0 : i-1]),
      .left_valid   ((i == 0) ? 1'b0         : c_valid[(i == 0) ? 0 : i-1]),
      .left_beyond  ((i == 0) ? 1'b0         : c_beyond[(i == 0) ? 0 : i-1]),
      .right_price  ((i == MAX_LEVELS-1) ? 32'd0 : c_price[(i == MAX_LEVELS-1) ? i : i+1]),
      .right_total  ((i == MAX_LEVELS-1) ? 32'd0 : c_total[(i == MAX_LEVELS-1) ? i : i+1]),
      .right_orders ((i == MAX_LEVELS-1) ? CNT_W'(0) :
                     c_orders[(i == MAX_LEVELS-1) ? i : i+1]),
      .right_valid  ((i == MAX_LEVELS-1) ? 1'b0  : c_valid[(i == MAX_LEVELS-1) ? i : i+1]),
      .price_o      (c_price[i]),
      .total_o      (c_total[i]),
      .orders_o     (c_orders[i]),
      .valid_o      (c_valid[i]),
      .beyond_o     (c_beyond[i]),
      .match_o      (c_match[i])
    );
  end

  always_comb begin
    st.hit      = 1'b0;
    st.hit_last = 1'b0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      st.hit      = st.hit | c_match[i];
      st.hit_last = st.hit_last | (c_match[i] && (c_orders[i] == CNT_W'(1)));
    end
    st.full     = c_valid[MAX_LEVELS-1];
    st.head_vld = c_valid[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (op.ins) begin
      used_r <= used_r + LCNT_W'(1);
    end else if (op.del) begin
      used_r <= used_r - LCNT_W'(1);
    end
  end

  assign used       = used_r;
  assign head_price = c_price[0];
  assign rd_price   = c_price[rd_idx];
  assign rd_total   = c_total[rd_idx];

endmodule
